// File: rtl/core/ele_pkg.sv
package ele_pkg;

  localparam int unsigned MaxSteps      = 127;
  localparam int unsigned CoordFracBits = 16;
  localparam int unsigned CountW        = 24;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [2:0] {
    REG_RADIUS_X = 3'd0,
    REG_RADIUS_Y = 3'd1,
    REG_RADIUS_Z = 3'd2,
    REG_CENTER_X = 3'd3,
    REG_CENTER_Y = 3'd4,
    REG_CENTER_Z = 3'd5,
    REG_HALF_STEPS = 3'd6
  } reg_idx_e;

  // datapath commands
  typedef struct packed {
    logic setup_start;  // latch min radius, start step/limit computation
    logic test_start;   // start inside test for current index
    logic advance;      // move index after a visit
    logic outside;      // advance is a row end
    logic emit_load;    // load mirror sequencer
    logic emit_next;    // one output beat taken
  } ele_cmd_t;

  typedef struct packed {
    logic setup_done;
    logic test_done;
    logic in_shape;
    logic finished;
    logic emit_last;
  } ele_sts_t;

endpackage

// File: rtl/core/ele_div.sv
// Restoring divider, one quotient bit per cycle.
module ele_div import ele_pkg::*; #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 31
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// File: rtl/core/ele_datapath.sv
module ele_datapath import ele_pkg::*; #(
  parameter int unsigned MAX_STEPS = MaxSteps
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  ele_cmd_t           cmd_i,
  output ele_sts_t           sts_o,
  output logic signed [31:0] px_o,
  output logic signed [31:0] py_o,
  output logic signed [31:0] pz_o,
  output logic               done_o,
  output logic [CountW-1:0]  count_o
);
  localparam int unsigned LimW = $clog2(MAX_STEPS + 1);

  logic [30:0] rad_q [3];
  logic [31:0] cen_q [3];
  logic [6:0]  half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q[0] <= 31'd65536;
      rad_q[1] <= 31'd65536;
      rad_q[2] <= 31'd65536;
      cen_q[0] <= '0;
      cen_q[1] <= '0;
      cen_q[2] <= '0;
      half_q   <= 7'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIUS_X:   rad_q[0] <= cfg_data_i[30:0];
        REG_RADIUS_Y:   rad_q[1] <= cfg_data_i[30:0];
        REG_RADIUS_Z:   rad_q[2] <= cfg_data_i[30:0];
        REG_CENTER_X:   cen_q[0] <= cfg_data_i;
        REG_CENTER_Y:   cen_q[1] <= cfg_data_i;
        REG_CENTER_Z:   cen_q[2] <= cfg_data_i;
        REG_HALF_STEPS: half_q   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  logic [30:0] reff [3];
  always_comb begin
    for (int a = 0; a < 3; a++) reff[a] = (rad_q[a] == '0) ? 31'd1 : rad_q[a];
  end

  // ---- shared divider ----
  logic        div_start, div_done;
  logic [63:0] div_num, div_quo;
  logic [30:0] div_den;

  ele_div #(.NumW(64), .DenW(31)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  // ---- sequencer of divider jobs ----
  // setup: job0 step, job1/2 ceil ratios for two other axes
  // test : job0..2 q per axis
  logic [1:0]  job_q, job_d;
  logic        mode_test_q, mode_test_d;
  logic        run_q, run_d;
  logic [1:0]  minax_q, minax_d;
  logic [30:0] rmin_q, rmin_d;
  logic [LimW-1:0] lim_q [3];
  logic [LimW-1:0] lim_d [3];
  logic [LimW-1:0] idx_q [3];
  logic [LimW-1:0] idx_d [3];
  logic [31:0] step_q, step_d;
  logic        fin_q, fin_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [63:0] sum_q, sum_d;
  logic        out_q, out_d;
  logic        sdone_q, tdone_q, sdone_d, tdone_d;
  logic [38:0] dist_q [3];
  logic [38:0] dist_d [3];
  logic [1:0]  dstage_q, dstage_d;
  logic [1:0]  other_ax [2];
  logic [63:0] q_sq;
  logic [31:0] qv;
  logic [38:0] lim_prod;
  logic [LimW-1:0] nsat;

  always_comb begin
    unique case (minax_q)
      2'd0:    begin other_ax[0] = 2'd1; other_ax[1] = 2'd2; end
      2'd1:    begin other_ax[0] = 2'd0; other_ax[1] = 2'd2; end
      default: begin other_ax[0] = 2'd0; other_ax[1] = 2'd1; end
    endcase
  end

  assign nsat = (32'(half_q) > MAX_STEPS) ? LimW'(MAX_STEPS) : LimW'(half_q);
  assign qv   = div_quo[31:0];
  assign q_sq = 64'(qv[30:0]) * 64'(qv[30:0]);

  always_comb begin
    job_d = job_q; mode_test_d = mode_test_q; run_d = run_q;
    minax_d = minax_q; rmin_d = rmin_q; step_d = step_q; fin_d = fin_q;
    cnt_d = cnt_q; sum_d = sum_q; out_d = out_q; dstage_d = dstage_q;
    sdone_d = 1'b0; tdone_d = 1'b0;
    for (int a = 0; a < 3; a++) begin
      lim_d[a]  = lim_q[a];
      idx_d[a]  = idx_q[a];
      dist_d[a] = dist_q[a];
    end
    div_start = 1'b0; div_num = '0; div_den = reff[0];
    lim_prod  = '0;

    if (cmd_i.setup_start) begin
      if (reff[1] < reff[0] && reff[1] <= reff[2]) begin
        minax_d = 2'd1; rmin_d = reff[1];
      end else if (reff[2] < reff[0] && reff[2] < reff[1]) begin
        minax_d = 2'd2; rmin_d = reff[2];
      end else begin
        minax_d = 2'd0; rmin_d = reff[0];
      end
      div_start = 1'b1;
      div_num   = 64'({rmin_d, 1'b0});
      div_den   = {23'd0, half_q, 1'b1};
      job_d = 2'd0; mode_test_d = 1'b0; run_d = 1'b1;
      for (int a = 0; a < 3; a++) idx_d[a] = '0;
      cnt_d = '0; fin_d = 1'b0;
    end else if (cmd_i.test_start) begin
      // distances: index*step, one multiply per cycle
      dstage_d = 2'd0; run_d = 1'b1; mode_test_d = 1'b1; job_d = 2'd3;
      sum_d = '0; out_d = 1'b0;
    end else if (run_q && mode_test_q && job_q == 2'd3) begin
      dist_d[dstage_q] = 39'(idx_q[dstage_q]) * 39'(step_q);
      if (dstage_q == 2'd2) begin
        job_d = 2'd0;
        // start first axis
        div_start = 1'b1;
      end
      dstage_d = dstage_q + 2'd1;
      if (dstage_q == 2'd2) begin
        if (dist_d[0] > 39'(reff[0])) begin
          out_d = 1'b1; run_d = 1'b0; tdone_d = 1'b1; div_start = 1'b0;
        end else begin
          div_num = {dist_d[0][33:0], 30'd0};
          div_den = reff[0];
        end
      end
    end else if (run_q && div_done) begin
      if (!mode_test_q) begin
        unique case (job_q)
          2'd0: begin
            step_d = div_quo[31:0];
            lim_d[minax_q] = nsat;
          end
          default: begin
            lim_prod = div_quo[38:0] * 39'(half_q);
            lim_d[other_ax[job_q[1]]] = (lim_prod > 39'(MAX_STEPS)) ?
                                        LimW'(MAX_STEPS) : LimW'(lim_prod);
          end
        endcase
        if (job_q == 2'd2) begin
          run_d = 1'b0; sdone_d = 1'b1;
        end else begin
          job_d     = job_q + 2'd1;
          div_start = 1'b1;
          div_num   = 64'(reff[other_ax[job_q[0]]]) + 64'(rmin_q) - 64'd1;
          div_den   = rmin_q;
        end
      end else begin
        sum_d = sum_q + q_sq;
        if (job_q == 2'd2) begin
          run_d = 1'b0; tdone_d = 1'b1;
          out_d = (sum_d > 64'h1000_0000_0000_0000);
        end else begin
          job_d = job_q + 2'd1;
          if (dist_q[job_d] > 39'(reff[job_d])) begin
            out_d = 1'b1; run_d = 1'b0; tdone_d = 1'b1;
          end else begin
            div_start = 1'b1;
            div_num   = {dist_q[job_d][33:0], 30'd0};
            div_den   = reff[job_d];
          end
        end
      end
    end

    if (cmd_i.advance) begin
      if (!cmd_i.outside && idx_q[0] < lim_q[0]) begin
        idx_d[0] = idx_q[0] + 1'b1;
      end else begin
        idx_d[0] = '0;
        if (idx_q[1] >= lim_q[1]) begin
          idx_d[1] = '0;
          if (idx_q[2] >= lim_q[2]) begin
            idx_d[2] = '0; fin_d = 1'b1;
          end else idx_d[2] = idx_q[2] + 1'b1;
        end else idx_d[1] = idx_q[1] + 1'b1;
      end
    end
    if (cmd_i.emit_next && cnt_q != CountMax) cnt_d = cnt_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; mode_test_q <= 1'b0; job_q <= '0; dstage_q <= '0;
      minax_q <= '0; fin_q <= 1'b1; cnt_q <= '0; step_q <= '0;
      sdone_q <= 1'b0; tdone_q <= 1'b0; out_q <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        lim_q[a] <= '0; idx_q[a] <= '0;
      end
    end else begin
      run_q <= run_d; mode_test_q <= mode_test_d; job_q <= job_d;
      dstage_q <= dstage_d; minax_q <= minax_d; fin_q <= fin_d;
      cnt_q <= cnt_d; step_q <= step_d; sdone_q <= sdone_d;
      tdone_q <= tdone_d; out_q <= out_d;
      for (int a = 0; a < 3; a++) begin
        lim_q[a] <= lim_d[a]; idx_q[a] <= idx_d[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rmin_q <= rmin_d;
    sum_q  <= sum_d;
    for (int a = 0; a < 3; a++) dist_q[a] <= dist_d[a];
  end

  // ---- mirror sequencer and coordinate outputs ----
  logic signed [33:0] plus_w [3];
  logic signed [33:0] minus_w [3];
  logic signed [31:0] pos_q [3];
  logic signed [31:0] neg_q [3];
  logic [2:0] msk_q, sel_q, sel_d, msk_d;
  logic       done_q, done_d;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647)       sat32 = 32'sh7fffffff;
    else if (v < -34'sd2147483648) sat32 = 32'sh80000000;
    else                           sat32 = v[31:0];
  endfunction

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      plus_w[a]  = 34'($signed(cen_q[a])) + $signed({1'b0, dist_q[a][32:0]});
      minus_w[a] = 34'($signed(cen_q[a])) - $signed({1'b0, dist_q[a][32:0]});
    end
  end

  always_comb begin
    sel_d = sel_q; msk_d = msk_q; done_d = done_q;
    if (cmd_i.emit_load) begin
      sel_d = '0;
      for (int a = 0; a < 3; a++) msk_d[a] = (idx_q[a] != '0);
      done_d = fin_d;
    end else if (cmd_i.emit_next) begin
      sel_d = ((sel_q | ~msk_q) + 3'd1) & msk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0; msk_q <= '0; done_q <= 1'b0;
    end else begin
      sel_q <= sel_d; msk_q <= msk_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      for (int a = 0; a < 3; a++) begin
        pos_q[a] <= sat32(plus_w[a]);
        neg_q[a] <= sat32(minus_w[a]);
      end
    end
  end

  assign px_o    = sel_q[0] ? neg_q[0] : pos_q[0];
  assign py_o    = sel_q[1] ? neg_q[1] : pos_q[1];
  assign pz_o    = sel_q[2] ? neg_q[2] : pos_q[2];
  assign done_o  = done_q;
  assign count_o = (cnt_q == CountMax) ? cnt_q : cnt_q + 1'b1;

  assign sts_o.setup_done = sdone_q;
  assign sts_o.test_done  = tdone_q;
  assign sts_o.in_shape   = !out_q;
  assign sts_o.finished   = fin_q;
  assign sts_o.emit_last  = (sel_q == msk_q);
endmodule

// File: rtl/core/ele_ctrl.sv
module ele_ctrl import ele_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_restart_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ele_cmd_t cmd_o,
  input  ele_sts_t sts_i
);
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_TEST  = 5'b00100,
    ST_LOAD  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_restart_i) begin
            cmd_o.setup_start = 1'b1;
            state_d = ST_SETUP;
          end else if (!sts_i.finished) begin
            cmd_o.test_start = 1'b1;
            state_d = ST_TEST;
          end
        end
      end
      ST_SETUP: begin
        if (sts_i.setup_done) begin
          cmd_o.test_start = 1'b1;
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sts_i.test_done) begin
          if (sts_i.in_shape) state_d = ST_LOAD;
          else begin
            cmd_o.advance = 1'b1;
            cmd_o.outside = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_LOAD: begin
        cmd_o.emit_load = 1'b1;
        cmd_o.advance   = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.emit_next = 1'b1;
          if (sts_i.emit_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end
endmodule

// File: rtl/core/ellipsoid_lattice_enumerator.sv
// Channel   Dir  Payload
// s_axis    in   tdata[0] restart
// m_axis    out  tdata point_x|point_y|point_z|points_so_far, tlast last_of_run,
//                tuser enumeration_done
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
// One input beat at a time. Restart: three divides (step and two axis limits),
// then a visit of up to one divide per axis (on the shared restoring divider),
// then one output beat per cycle while m_axis_tready is high.
// Reset: async, active low; no enumeration runs until a restart beat.
// Output stalls hold the block; s_axis_tready is low while an item is in work.
module ellipsoid_lattice_enumerator import ele_pkg::*; #(
  parameter int unsigned MAX_STEPS = MaxSteps
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [0] restart
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [119:0]  m_axis_tdata,   // point_x, point_y, point_z, points_so_far
  output logic          m_axis_tlast,   // last_of_run
  output logic          m_axis_tuser    // enumeration_done
);
  ele_cmd_t cmd;
  ele_sts_t sts;
  logic signed [31:0] px, py, pz;
  logic [CountW-1:0]  cnt;
  logic               done;

  ele_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_restart_i(s_axis_tdata[0]),
    .in_ready_o(s_axis_tready), .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready), .cmd_o(cmd), .sts_i(sts)
  );

  ele_datapath #(.MAX_STEPS(MAX_STEPS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_i(cmd), .sts_o(sts), .px_o(px), .py_o(py), .pz_o(pz),
    .done_o(done), .count_o(cnt)
  );

  assign m_axis_tdata = {cnt, pz, py, px};
  assign m_axis_tlast = sts.emit_last;
  assign m_axis_tuser = done;
endmodule

// File: rtl/core/ele_checker.sv
module ele_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [119:0] m_axis_tdata,
  input logic         m_axis_tlast
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while output pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid) else $error("output too early");

  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("beats after last");
endmodule

bind ellipsoid_lattice_enumerator ele_checker u_ele_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);

// File: verif/ellipsoid_lattice_enumerator_checker.sv
module ellipsoid_lattice_enumerator_checker import ele_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [119:0] m_axis_tdata,
  input  logic         m_axis_tlast,
  input  logic         m_axis_tuser,
  output int           fails_o,
  output int           pending_o,
  output int           points_seen_o
);

  typedef struct packed {
    logic [31:0]       px;
    logic [31:0]       py;
    logic [31:0]       pz;
    logic              last;
    logic              done;
    logic [CountW-1:0] count;
  } lattice_point_t;

  lattice_point_t points_q[$];

  logic [30:0] rad_x, rad_y, rad_z;
  logic [31:0] ctr_x, ctr_y, ctr_z;
  logic [6:0]  n_half;
  logic [7:0]  idx_i, idx_j, idx_k, lim_i, lim_j, lim_k;
  logic [31:0] pitch;
  logic [CountW-1:0] emitted;
  logic        walk_done;

  function automatic longint unsigned eff_rad(logic [30:0] r);
    return (r == 0) ? 64'd1 : {33'd0, r};
  endfunction

  function automatic logic [7:0] lim_of(longint unsigned r, longint unsigned rmin,
                                        longint unsigned n);
    longint unsigned v;
    v = ((r + rmin - 1) / rmin) * n;
    return (v > MaxSteps) ? 8'(MaxSteps) : v[7:0];
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic bit ratio_sq(longint unsigned d, longint unsigned r,
                                  inout longint unsigned acc);
    longint unsigned q;
    if (d > r) return 0;
    q = (d << 30) / r;
    acc += q * q;
    return 1;
  endfunction

  task automatic start_walk();
    longint unsigned rx, ry, rz, rmin, n;
    rx = eff_rad(rad_x); ry = eff_rad(rad_y); rz = eff_rad(rad_z);
    n = n_half;
    rmin = rx;
    if (ry < rmin) rmin = ry;
    if (rz < rmin) rmin = rz;
    pitch = 32'((2 * rmin) / (2 * n + 1));
    if (rx == rmin) begin
      lim_i = 8'(n); lim_j = lim_of(ry, rmin, n); lim_k = lim_of(rz, rmin, n);
    end else if (ry == rmin) begin
      lim_j = 8'(n); lim_i = lim_of(rx, rmin, n); lim_k = lim_of(rz, rmin, n);
    end else begin
      lim_k = 8'(n); lim_i = lim_of(rx, rmin, n); lim_j = lim_of(ry, rmin, n);
    end
    idx_i = 0; idx_j = 0; idx_k = 0;
    emitted = 0;
    walk_done = 0;
  endtask

  task automatic end_row();
    idx_i = 0;
    if (idx_j >= lim_j) begin
      idx_j = 0;
      if (idx_k >= lim_k) begin
        idx_k = 0; walk_done = 1;
      end else begin
        idx_k++;
      end
    end else begin
      idx_j++;
    end
  endtask

  task automatic visit_point(bit restart);
    longint unsigned dx, dy, dz, acc;
    longint cx, cy, cz;
    logic [31:0] px[8], py[8], pz[8];
    int np;
    bit hit;
    lattice_point_t p;
    acc = 0;
    if (restart) start_walk();
    else if (walk_done) return;
    cx = longint'(signed'(ctr_x)); cy = longint'(signed'(ctr_y));
    cz = longint'(signed'(ctr_z));
    dx = idx_i * pitch; dy = idx_j * pitch; dz = idx_k * pitch;
    hit = ratio_sq(dx, eff_rad(rad_x), acc) && ratio_sq(dy, eff_rad(rad_y), acc)
          && ratio_sq(dz, eff_rad(rad_z), acc) && (acc <= (64'd1 << 60));
    if (!hit) begin
      end_row();
      return;
    end
    px[0] = sat32(cx + longint'(dx));
    py[0] = sat32(cy + longint'(dy));
    pz[0] = sat32(cz + longint'(dz));
    np = 1;
    if (idx_i > 0) begin
      px[1] = sat32(cx - longint'(dx)); py[1] = py[0]; pz[1] = pz[0];
      np = 2;
    end
    if (idx_j > 0) begin
      for (int m = 0; m < np; m++) begin
        px[np+m] = px[m]; py[np+m] = sat32(cy - longint'(dy)); pz[np+m] = pz[m];
      end
      np *= 2;
    end
    if (idx_k > 0) begin
      for (int m = 0; m < np; m++) begin
        px[np+m] = px[m]; py[np+m] = py[m]; pz[np+m] = sat32(cz - longint'(dz));
      end
      np *= 2;
    end
    if (idx_i >= lim_i) end_row();
    else idx_i++;
    for (int m = 0; m < np; m++) begin
      if (emitted != CountMax) emitted++;
      p.px = px[m]; p.py = py[m]; p.pz = pz[m];
      p.last = (m == np - 1);
      p.done = walk_done;
      p.count = emitted;
      points_q.insert(points_q.size(), p);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lattice_point_t want, got;
    if (!rst_ni) begin
      rad_x = 31'd65536; rad_y = 31'd65536; rad_z = 31'd65536;
      ctr_x = '0; ctr_y = '0; ctr_z = '0;
      n_half = 7'd4;
      idx_i = 0; idx_j = 0; idx_k = 0; lim_i = 0; lim_j = 0; lim_k = 0;
      pitch = 0; emitted = 0; walk_done = 1;
      fails_o <= 0;
      points_seen_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RADIUS_X:   rad_x = cfg_data_i[30:0];
          REG_RADIUS_Y:   rad_y = cfg_data_i[30:0];
          REG_RADIUS_Z:   rad_z = cfg_data_i[30:0];
          REG_CENTER_X:   ctr_x = cfg_data_i;
          REG_CENTER_Y:   ctr_y = cfg_data_i;
          REG_CENTER_Z:   ctr_z = cfg_data_i;
          REG_HALF_STEPS: n_half = cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) visit_point(s_axis_tdata[0]);
      if (m_axis_tvalid && m_axis_tready) begin
        points_seen_o <= points_seen_o + 1;
        got.px = m_axis_tdata[31:0];
        got.py = m_axis_tdata[63:32];
        got.pz = m_axis_tdata[95:64];
        got.count = m_axis_tdata[119:96];
        got.last = m_axis_tlast;
        got.done = m_axis_tuser;
        if (points_q.size() == 0) begin
          if (fails_o < 10) $display("unexpected point beat: %p", got);
          fails_o <= fails_o + 1;
        end else begin
          want = points_q.pop_front();
          if (got !== want) begin
            if (fails_o < 10) $display("point mismatch: expected %p, got %p", want, got);
            fails_o <= fails_o + 1;
          end
        end
      end
      pending_o <= points_q.size();
    end
  end

endmodule

// File: verif/ellipsoid_lattice_enumerator_tb.sv
module ellipsoid_lattice_enumerator_tb import ele_pkg::*;;

  localparam logic [2:0] RegUnused = 3'd7;
  localparam int DrainCycles = 600;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         cfg_we_i = 0;
  logic [2:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [119:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         m_axis_tuser;
  int           fails, pending, points_seen;
  int           gap_pct = 0, stall_pct = 0;
  int           visits = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  ellipsoid_lattice_enumerator dut (.*);

  ellipsoid_lattice_enumerator_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .fails_o(fails), .pending_o(pending), .points_seen_o(points_seen)
  );

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic send_visit(bit restart);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {7'd0, restart};
    forever begin
      @(negedge clk_i);
      if (s_axis_tready) break;
    end
    @(posedge clk_i);
    visits++;
    if ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 0;
      while ($urandom_range(99) < gap_pct) @(posedge clk_i);
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    forever begin
      @(negedge clk_i);
      if (pending == 0 && s_axis_tready) break;
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_radius(logic [31:0] base);
    case ($urandom_range(9))
      0: return {1'($urandom_range(1)), 31'd0};
      1: return 32'h7fffffff;
      2: return $urandom();
      default: return {1'($urandom_range(1)), 31'(base * $urandom_range(1, 3))};
    endcase
  endfunction

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [31:0] base;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // walk under the reset configuration, including visits before any restart
    send_visit(0);
    send_visit(0);
    send_visit(1);
    repeat (20) send_visit(0);
    drain();
    for (int ph = 1; ph <= 11; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 74; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 74; end
        default: begin gap_pct = 13; stall_pct = 13; end
      endcase
      base = $urandom_range(1, 1 << 20);
      if (ph == 1) begin
        write_reg(REG_RADIUS_X, 32'hffffffff);
        write_reg(REG_RADIUS_Y, 32'h7fffffff);
        write_reg(REG_RADIUS_Z, 32'h7fffffff);
        write_reg(REG_CENTER_X, 32'h7fffffff);
        write_reg(REG_CENTER_Y, 32'h80000000);
        write_reg(REG_CENTER_Z, 32'h7ffff000);
        write_reg(REG_HALF_STEPS, 32'd127);
      end else if (ph == 2) begin
        write_reg(REG_RADIUS_X, 32'h80000000);
        write_reg(REG_RADIUS_Y, 32'd0);
        write_reg(REG_RADIUS_Z, 32'd5);
        write_reg(REG_CENTER_X, 32'h80000000);
        write_reg(REG_CENTER_Y, 32'hffffffff);
        write_reg(REG_CENTER_Z, 32'h80000000);
        write_reg(REG_HALF_STEPS, 32'hffffff80);
        write_reg(RegUnused, $urandom());
      end else begin
        write_reg(REG_RADIUS_X, pick_radius(base));
        write_reg(REG_RADIUS_Y, pick_radius(base));
        write_reg(REG_RADIUS_Z, pick_radius(base));
        write_reg(REG_CENTER_X, $urandom());
        write_reg(REG_CENTER_Y, $urandom());
        write_reg(REG_CENTER_Z, $urandom());
        write_reg(REG_HALF_STEPS,
                  ($urandom_range(9) == 0) ? $urandom() : $urandom_range(0, 5));
      end
      cfg_we_i <= 0;
      @(posedge clk_i);
      send_visit(1);
      for (int it = 0; it < 31; it++) begin
        if (ph == 3 && it == 10) begin
          s_axis_tvalid <= 0;
          forever begin
            @(negedge clk_i);
            if (pending == 0) break;
          end
          @(posedge clk_i);
        end
        send_visit($urandom_range(99) < 4);
      end
      drain();
    end
    $display("visited %0d lattice points over 12 configurations, %0d points checked",
             visits, points_seen);
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
